// ----- rtl/perceptron_train_step_defines.svh -----
// ---------------------------------------------------------------------------
// Perceptron training step: assertion macros
// Shared concurrent assertion forms, compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef PERCEPTRON_TRAIN_STEP_DEFINES_SVH
`define PERCEPTRON_TRAIN_STEP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define PT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Next-cycle implication, checked outside reset.
`define PT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PT_ASSERT(lbl, prop, msg)
`define PT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/pcpt_pkg.sv -----
// ---------------------------------------------------------------------------
// Perceptron training step: package
// Sizes, codes and the beat types passed between the pipeline stages.
// ---------------------------------------------------------------------------
package pcpt_pkg;

  localparam int WEIGHT_COUNT = 16;
  localparam int VALUE_WIDTH  = 16;

  localparam int IN_W      = 16;  // point and bias input fields
  localparam int LR_W      = 16;  // learning rate field
  localparam int CNT_W     = 5;   // weights_in_use field
  localparam int IDXF_W    = 4;   // weight_index field
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam int IDX_W   = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
  localparam int CLAMP_W = 9;     // holds WEIGHT_COUNT up to 256

  localparam int MUL_W   = IN_W + LR_W + 1;
  localparam int RND_W   = IN_W + 1;
  localparam int DELTA_W = RND_W + 1;
  localparam int SUM_W   = ((VALUE_WIDTH > DELTA_W) ? VALUE_WIDTH : DELTA_W) + 1;
  localparam int PROD_W  = IN_W + VALUE_WIDTH;
  localparam int DOT_W   = PROD_W + 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [0:0] {
    OP_INFER = 1'b0,
    OP_TRAIN = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_PLUS  = 2'd1,
    ERR_MINUS = 2'd2
  } err_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIAS_INPUT     = 2'd0,
    CFG_LEARN_RATE     = 2'd1,
    CFG_WEIGHTS_IN_USE = 2'd2
  } cfg_index_t;

  typedef logic signed [VALUE_WIDTH-1:0] weight_t;
  typedef logic signed [IN_W-1:0]        in_t;
  typedef logic signed [DELTA_W-1:0]     delta_t;

  typedef struct packed {
    in_t              bias_input;
    logic [LR_W-1:0]  learn_rate;
    logic [CNT_W-1:0] weights_in_use;
  } cfg_t;

  // Beat between the prep stage and the update stage.
  typedef struct packed {
    opcode_t          train;
    logic             desired;
    logic [IDX_W-1:0] idx;
    in_t              x;
    in_t              y;
    delta_t           dx;
    delta_t           dy;
    delta_t           db;
  } item_t;

  typedef struct packed {
    logic      guess;
    err_code_t err;
    in_t       wx;
    in_t       wy;
    in_t       wb;
  } result_t;

  // Bring a stored weight to the 16-bit result field.
  function automatic in_t to_field(weight_t w);
    logic signed [SUM_W-1:0] ext;
    ext = SUM_W'(w);
    return ext[IN_W-1:0];
  endfunction

endpackage

// ----- rtl/pcpt_prep.sv -----
// ---------------------------------------------------------------------------
// Perceptron training step: prep stage
// Registers the input beat, clamps the index and forms the rounded
// learning-rate deltas, none of which depend on the weight table.
// ---------------------------------------------------------------------------
module pcpt_prep
  import pcpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              s_valid,
  output logic              s_ready,
  input  opcode_t           s_opcode,
  input  in_t               s_x,
  input  in_t               s_y,
  input  logic [IDXF_W-1:0] s_idx,
  input  logic              s_desired,
  output logic              m_valid,
  input  logic              m_ready,
  output item_t             m_item
);

  logic  a_valid_r, a_valid_nxt;
  item_t a_item_r,  a_item_nxt;
  logic  s_fire;
  logic [CLAMP_W-1:0] cnt_c;
  logic [CLAMP_W-1:0] idx_c;

  // round(|v * lr * 2| / 2^16) ties away from zero, sign of v applied back
  function automatic delta_t scale(in_t v, logic [LR_W-1:0] lr);
    logic signed [MUL_W-1:0] q;
    logic [MUL_W-1:0]        mag;
    logic [MUL_W-1:0]        rs;
    logic [DELTA_W-1:0]      r;
    q   = v * $signed({1'b0, lr});
    mag = q[MUL_W-1] ? MUL_W'(-q) : MUL_W'(q);
    rs  = mag + (MUL_W'(1) << (LR_W - 2));
    r   = {1'b0, rs[MUL_W-2:LR_W-1]};
    return q[MUL_W-1] ? delta_t'(-r) : delta_t'(r);
  endfunction

  assign s_ready = !a_valid_r || m_ready;
  assign s_fire  = s_valid && s_ready;
  assign m_valid = a_valid_r;
  assign m_item  = a_item_r;

  always_comb begin
    if (cfg.weights_in_use == '0) begin
      cnt_c = CLAMP_W'(1);
    end else if (CLAMP_W'(cfg.weights_in_use) > CLAMP_W'(WEIGHT_COUNT)) begin
      cnt_c = CLAMP_W'(WEIGHT_COUNT);
    end else begin
      cnt_c = CLAMP_W'(cfg.weights_in_use);
    end
    // out-of-range index selects the last pair in use
    if (CLAMP_W'(s_idx) >= cnt_c) begin
      idx_c = cnt_c - CLAMP_W'(1);
    end else begin
      idx_c = CLAMP_W'(s_idx);
    end
  end

  always_comb begin
    a_item_nxt.train   = s_opcode;
    a_item_nxt.desired = s_desired;
    a_item_nxt.idx     = idx_c[IDX_W-1:0];
    a_item_nxt.x       = s_x;
    a_item_nxt.y       = s_y;
    a_item_nxt.dx      = scale(s_x, cfg.learn_rate);
    a_item_nxt.dy      = scale(s_y, cfg.learn_rate);
    a_item_nxt.db      = scale(cfg.bias_input, cfg.learn_rate);
    if (s_fire) begin
      a_valid_nxt = 1'b1;
    end else if (m_ready) begin
      a_valid_nxt = 1'b0;
    end else begin
      a_valid_nxt = a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      a_item_r <= a_item_nxt;
    end
  end

endmodule

// ----- rtl/pcpt_core.sv -----
// ---------------------------------------------------------------------------
// Perceptron training step: update stage
// Holds the weight table and bias weight, forms the weighted sum and guess,
// and writes the saturated update back in the same cycle.
// ---------------------------------------------------------------------------
`include "perceptron_train_step_defines.svh"

module pcpt_core
  import pcpt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  in_t     bias_input,
  input  item_t   item,
  input  logic    fire,
  output result_t res
);

  weight_t wx_r [WEIGHT_COUNT];
  weight_t wy_r [WEIGHT_COUNT];
  weight_t wb_r;

  weight_t wx, wy;
  logic signed [PROD_W-1:0] px, py, pb;
  logic signed [DOT_W-1:0]  dot;
  logic    guess;
  logic    miss;
  logic    upd;
  weight_t nx, ny, nb;

  function automatic weight_t sat_add(weight_t w, delta_t d, logic pos);
    logic signed [SUM_W-1:0]           s;
    logic [SUM_W-VALUE_WIDTH:0]        hi;
    s  = pos ? (SUM_W'(w) + SUM_W'(d)) : (SUM_W'(w) - SUM_W'(d));
    hi = s[SUM_W-1:VALUE_WIDTH-1];
    if (hi == '0 || hi == '1) begin
      return s[VALUE_WIDTH-1:0];
    end else if (s[SUM_W-1]) begin
      return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
  endfunction

  assign wx = wx_r[item.idx];
  assign wy = wy_r[item.idx];

  always_comb begin
    px    = item.x * wx;
    py    = item.y * wy;
    pb    = bias_input * wb_r;
    dot   = DOT_W'(px) + DOT_W'(py) + DOT_W'(pb);
    guess = (dot > 0);  // a zero sum guesses negative
    miss  = (item.train == OP_TRAIN) && (item.desired != guess);
    upd   = fire && miss;
    nx    = sat_add(wx,   item.dx, item.desired);
    ny    = sat_add(wy,   item.dy, item.desired);
    nb    = sat_add(wb_r, item.db, item.desired);

    res.guess = guess;
    if (!miss) begin
      res.err = ERR_NONE;
    end else if (item.desired) begin
      res.err = ERR_PLUS;
    end else begin
      res.err = ERR_MINUS;
    end
    res.wx = to_field(miss ? nx : wx);
    res.wy = to_field(miss ? ny : wy);
    res.wb = to_field(miss ? nb : wb_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WEIGHT_COUNT; i++) begin
        wx_r[i] <= '0;
        wy_r[i] <= '0;
      end
      wb_r <= '0;
    end else if (upd) begin
      wx_r[item.idx] <= nx;
      wy_r[item.idx] <= ny;
      wb_r           <= nb;
    end
  end

  `PT_ASSERT_NEXT(a_bias_hold, !upd, $stable(wb_r), "bias weight moved without an update")
  `PT_ASSERT_NEXT(a_x_written, upd, wx_r[$past(item.idx)] == $past(nx), "weight x not written")
  `PT_ASSERT(a_upd_on_miss, upd |-> (res.err != ERR_NONE), "update without an error code")

endmodule

// ----- rtl/perceptron_train_step.sv -----
// ---------------------------------------------------------------------------
// Perceptron training step: top level
// Stream in points, get the guess and the weights after each step.
// ---------------------------------------------------------------------------
// Takes one beat per cycle while the result stream is not stalled and returns one
// result beat per input beat, through the prep register, then the result register. The weight
// table read, weighted sum, guess and saturated update all close within the
// update stage, so the next beat always sees the updated weights.
// Weights reset to zero directly; no clearing pass. Configuration writes are
// taken every cycle; make them only while no beat is in flight, since the
// bias input is read again when a beat reaches the update stage.
`include "perceptron_train_step_defines.svh"

module perceptron_train_step
  import pcpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DAT_W-1:0]   cfg_data,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // point_x[15:0], point_y[31:16], weight_index[35:32], desired_positive[36]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode[0]
  input  logic                   in_tuser,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // guess_positive[0], error_code[2:1], new_weight_x[18:3],
  // new_weight_y[34:19], new_bias_weight[50:35]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cfg_t    cfg_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t res;
  item_t   a_item;
  logic    a_valid;
  logic    b_adv;
  logic    fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bias_input     <= in_t'(256);
      cfg_r.learn_rate     <= LR_W'(655);
      cfg_r.weights_in_use <= CNT_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BIAS_INPUT:     cfg_r.bias_input     <= cfg_data[IN_W-1:0];
        CFG_LEARN_RATE:     cfg_r.learn_rate     <= cfg_data[LR_W-1:0];
        CFG_WEIGHTS_IN_USE: cfg_r.weights_in_use <= cfg_data[CNT_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  assign b_adv = !out_valid_r || out_tready;
  assign fire  = a_valid && b_adv;

  pcpt_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .s_valid   (in_tvalid),
    .s_ready   (in_tready),
    .s_opcode  (opcode_t'(in_tuser)),
    .s_x       (in_tdata[15:0]),
    .s_y       (in_tdata[31:16]),
    .s_idx     (in_tdata[35:32]),
    .s_desired (in_tdata[36]),
    .m_valid   (a_valid),
    .m_ready   (b_adv),
    .m_item    (a_item)
  );

  pcpt_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .bias_input (cfg_r.bias_input),
    .item       (a_item),
    .fire       (fire),
    .res        (res)
  );

  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r.wb, out_res_r.wy, out_res_r.wx,
                       out_res_r.err, out_res_r.guess};

  `PT_ASSERT(a_plus_guess,
             (out_valid_r && out_res_r.err == ERR_PLUS) |-> !out_res_r.guess,
             "positive error with positive guess")
  `PT_ASSERT(a_minus_guess,
             (out_valid_r && out_res_r.err == ERR_MINUS) |-> out_res_r.guess,
             "negative error with negative guess")
  `PT_ASSERT_NEXT(a_prep_hold, a_valid && !b_adv, a_valid && $stable(a_item),
                  "prep beat lost under stall")

endmodule

// ----- verif/perceptron_train_step_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Perceptron training step: testbench
// Drives points through the block, tracks the weight table on the side and
// checks every result beat. Runs directed corner cases first, then random
// training runs against hidden separating lines, with random register
// settings and random gaps and back-pressure on both streams.
// ---------------------------------------------------------------------------
module perceptron_train_step_tb;
  import pcpt_pkg::*;

  localparam int                   CYCLE_LIMIT  = 400000;
  localparam int                   DRAIN_CYCLES = 4;   // two-stage pipe plus margin
  localparam int                   MAX_REPORTS  = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;

  typedef struct {
    logic      guess;
    err_code_t err;
    in_t       wx;
    in_t       wy;
    in_t       wb;
  } step_result_t;

  // Tracks the weight table and the registers, and holds the results owed.
  class weight_book;
    in_t              bias_in;
    logic [LR_W-1:0]  rate;
    logic [CNT_W-1:0] in_use;
    in_t              wx [WEIGHT_COUNT];
    in_t              wy [WEIGHT_COUNT];
    in_t              bw;
    step_result_t     steps_due[$];
    int               mismatches;

    function void clear();
      bias_in = 16'sd256;
      rate    = 16'd655;
      in_use  = 5'd1;
      for (int i = 0; i < WEIGHT_COUNT; i++) begin
        wx[i] = '0;
        wy[i] = '0;
      end
      bw = '0;
      steps_due.delete();
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        CFG_BIAS_INPUT:     bias_in = val;
        CFG_LEARN_RATE:     rate = val;
        CFG_WEIGHTS_IN_USE: in_use = val[CNT_W-1:0];
        default: ;          // unmapped index: drop
      endcase
    endfunction

    // round(v * rate * step / 2^16), ties away from zero
    function longint learn_delta(in_t v, int step);
      longint p, mag, r;
      p = longint'(v) * longint'(rate) * step;
      mag = (p < 0) ? -p : p;
      r = (mag + 32768) >>> 16;
      return (p < 0) ? -r : r;
    endfunction

    function in_t saturate(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return in_t'(v);
    endfunction

    function void take_point(opcode_t op, in_t x, in_t y, logic [IDXF_W-1:0] idx,
                             logic des);
      int unsigned  n, sel;
      longint       acc;
      int           step;
      step_result_t e;
      n = 32'(in_use);
      if (n == 0) n = 1;
      if (n > WEIGHT_COUNT) n = WEIGHT_COUNT;
      sel = 32'(idx);
      if (sel >= n) sel = n - 1;
      acc = longint'(x) * longint'(wx[sel]) + longint'(y) * longint'(wy[sel])
          + longint'(bias_in) * longint'(bw);
      e.guess = (acc > 0);
      e.err = ERR_NONE;
      if (op == OP_TRAIN && des != e.guess) begin
        step = des ? 2 : -2;
        e.err = des ? ERR_PLUS : ERR_MINUS;
        wx[sel] = saturate(longint'(wx[sel]) + learn_delta(x, step));
        wy[sel] = saturate(longint'(wy[sel]) + learn_delta(y, step));
        bw      = saturate(longint'(bw) + learn_delta(bias_in, step));
      end
      e.wx = wx[sel];
      e.wy = wy[sel];
      e.wb = bw;
      steps_due.push_back(e);
    endfunction

    function void field_check(string name, longint got, longint want);
      if (got != want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
      end
    endfunction

    function void check_step(logic [OUT_TDATA_W-1:0] d);
      step_result_t want;
      if (steps_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result beat with nothing expected: %h", $realtime, d);
        return;
      end
      want = steps_due.pop_front();
      field_check("guess_positive", d[0], want.guess);
      field_check("error_code", d[2:1], want.err);
      field_check("new_weight_x", $signed(d[18:3]), want.wx);
      field_check("new_weight_y", $signed(d[34:19]), want.wy);
      field_check("new_bias_weight", $signed(d[50:35]), want.wb);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DAT_W-1:0]   cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // x, y, index, desired (low bit up)
  logic                   in_tuser = 1'b0; // opcode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // guess, error, wx, wy, bias weight

  weight_book book;
  int         send_gap_pct = 0;
  int         recv_stall_pct = 0;
  int         cycles = 0;

  perceptron_train_step u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_step(out_tdata);
  end

  task automatic send_point(opcode_t op, in_t x, in_t y, logic [IDXF_W-1:0] idx,
                            logic des);
    @(negedge clk);
    // idle the stream with random gaps before the beat
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {3'b000, des, idx, y, x};
    in_tuser = op;
    do @(posedge clk); while (!in_tready);
    book.take_point(op, x, y, idx, des);
  endtask

  // Hold the input stream until every owed result has come back.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (book.steps_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    book.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic shuffle_regs();
    logic [15:0] b, r;
    case ($urandom_range(3, 0))
      0: b = 16'($urandom);
      1: b = 16'd256;
      2: b = $urandom_range(1, 0) ? 16'h7fff : 16'h8000;
      default: b = 16'($urandom_range(1024, 0) - 512);
    endcase
    case ($urandom_range(4, 0))
      0: r = 16'($urandom);
      1: r = 16'd655;
      2: r = $urandom_range(1, 0) ? 16'hffff : 16'h0000;
      default: r = 16'($urandom_range(4095, 1));
    endcase
    write_reg(CFG_BIAS_INPUT, b);
    write_reg(CFG_LEARN_RATE, r);
    write_reg(CFG_WEIGHTS_IN_USE,
              16'($urandom_range(1, 0) ? $urandom_range(31, 0) : $urandom_range(16, 1)));
    if ($urandom_range(7, 0) == 0) write_reg(CFG_UNUSED, 16'($urandom));
  endtask

  function automatic in_t pick_coord();
    case ($urandom_range(9, 0))
      0: return $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
      1, 2: return in_t'($urandom);
      default: return in_t'(int'($urandom_range(2047, 0)) - 1024);
    endcase
  endfunction

  // Mostly training runs labeled by a hidden line, some inference and noise.
  task automatic run_random(int count);
    int      a, b, c, pick;
    in_t     x, y;
    longint  side;
    opcode_t op;
    logic    des;
    for (int i = 0; i < count; i++) begin
      if (i % 130 == 0) begin
        settle();
        shuffle_regs();
        a = int'($urandom_range(8, 0)) - 4;
        b = int'($urandom_range(8, 0)) - 4;
        c = int'($urandom_range(6, 0)) - 3;
      end
      x = pick_coord();
      y = pick_coord();
      side = a * longint'(x) + b * longint'(y) + c * 256;
      pick = $urandom_range(99, 0);
      op = (pick < 70 || pick >= 88) ? OP_TRAIN : OP_INFER;
      des = (pick < 70) ? (side > 0) : 1'($urandom_range(1, 0));
      send_point(op, x, y, 4'($urandom_range(15, 0)), des);
    end
  endtask

  initial begin
    book = new;
    book.clear();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_gap_pct = 28;
    recv_stall_pct = 65;
    // reset settings: sum of zero, desired ignored on infer, clamped index
    send_point(OP_INFER, 16'sd0, 16'sd0, 4'd0, 1'b1);
    send_point(OP_TRAIN, 16'sd0, 16'sd0, 4'd0, 1'b1);
    send_point(OP_TRAIN, 16'sh0100, 16'shff00, 4'd9, 1'b0);
    send_point(OP_TRAIN, 16'sh7fff, 16'sh8000, 4'd15, 1'b1);
    send_point(OP_INFER, 16'sh8000, 16'sh7fff, 4'd0, 1'b0);
    send_point(OP_TRAIN, 16'sh8000, 16'sh8000, 4'd0, 1'b0);

    // full learning rate drives the weights into saturation; zero count
    settle();
    write_reg(CFG_LEARN_RATE, 16'hffff);
    write_reg(CFG_BIAS_INPUT, 16'h8000);
    write_reg(CFG_WEIGHTS_IN_USE, 16'd0);
    repeat (2) send_point(OP_TRAIN, 16'sh7fff, 16'sh8000, 4'd3, 1'b1);
    repeat (2) send_point(OP_TRAIN, 16'sh7fff, 16'sh8000, 4'd3, 1'b0);

    // count past the table, zero rate, unmapped register
    settle();
    write_reg(CFG_WEIGHTS_IN_USE, 16'd31);
    write_reg(CFG_BIAS_INPUT, 16'h7fff);
    write_reg(CFG_LEARN_RATE, 16'h0000);
    write_reg(CFG_UNUSED, 16'hffff);
    send_point(OP_TRAIN, 16'sd300, -16'sd300, 4'd15, 1'b1);
    send_point(OP_TRAIN, 16'sd300, -16'sd300, 4'd15, 1'b0);
    send_point(OP_INFER, 16'sd300, 16'sd300, 4'd8, 1'b0);

    settle();
    write_reg(CFG_WEIGHTS_IN_USE, 16'd17);
    write_reg(CFG_LEARN_RATE, 16'd1);
    send_point(OP_TRAIN, 16'sh7fff, 16'sh7fff, 4'd15, 1'b0);
    send_point(OP_TRAIN, -16'sd1, 16'sd1, 4'd0, 1'b1);

    // rounding ties, then shrink the count and grow it back
    settle();
    write_reg(CFG_WEIGHTS_IN_USE, 16'd5);
    write_reg(CFG_LEARN_RATE, 16'd16384);
    write_reg(CFG_BIAS_INPUT, 16'd256);
    send_point(OP_TRAIN, 16'sd1, -16'sd1, 4'd2, 1'b1);
    send_point(OP_TRAIN, 16'sd1, -16'sd1, 4'd2, 1'b0);
    send_point(OP_TRAIN, 16'sd512, 16'sd77, 4'd12, 1'b1);
    send_point(OP_INFER, 16'sd512, 16'sd77, 4'd15, 1'b0);
    settle();
    write_reg(CFG_WEIGHTS_IN_USE, 16'd16);
    send_point(OP_INFER, 16'sd100, -16'sd100, 4'd15, 1'b0);
    send_point(OP_INFER, 16'sd512, 16'sd77, 4'd4, 1'b0);

    run_random(650);
    send_gap_pct = 65;
    recv_stall_pct = 28;
    run_random(650);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    run_random(650);

    settle();
    if (book.mismatches == 0 && book.steps_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pcpt_pkg.sv
rtl/pcpt_prep.sv
rtl/pcpt_core.sv
rtl/perceptron_train_step.sv
verif/perceptron_train_step_tb.sv
